// ===== rtl/urb_pkg.sv =====
// Shared constants, types and helpers for the serial receive/transmit ring block.
package urb_pkg;

  localparam int RX_DEPTH = 128;
  localparam int TX_DEPTH = 128;

  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_FW = $clog2(RX_DEPTH + 1);
  localparam int TX_FW = $clog2(TX_DEPTH + 1);

  localparam int MAX_FW = (RX_FW > TX_FW) ? RX_FW : TX_FW;
  localparam int SAT_W  = (MAX_FW > 9) ? MAX_FW : 9;
  localparam int ADM_W  = ((TX_FW > 8) ? TX_FW : 8) + 1;

  localparam logic [7:0] BYTE_MAX = 8'hFF;

  localparam logic [2:0] ACT_LINE_BYTE  = 3'd0;
  localparam logic [2:0] ACT_HOST_READ  = 3'd1;
  localparam logic [2:0] ACT_HOST_WRITE = 3'd2;
  localparam logic [2:0] ACT_TX_READY   = 3'd3;
  localparam logic [2:0] ACT_CLR_OVF    = 3'd4;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] line_byte;
    logic       line_error;
    logic [7:0] write_byte;
    logic       burst_first;
    logic [7:0] burst_len;
  } cmd_t;

  // Per-item status handed from the ring control to the result stage
  typedef struct packed {
    logic       rx_pop;
    logic       tx_pop;
    logic       write_accepted;
    logic       overflow_seen;
    logic [7:0] rx_level;
    logic       rx_empty;
    logic [7:0] tx_level;
    logic       tx_request;
  } step_info_t;

  function automatic logic [7:0] sat_level(input logic [SAT_W-1:0] v);
    logic [7:0] r;
    if (v > SAT_W'(BYTE_MAX)) begin
      r = BYTE_MAX;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/urb_if.sv =====
// Handshake channels for command items and result items.
interface urb_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] line_byte;
  logic       line_error;
  logic [7:0] write_byte;
  logic       burst_first;
  logic [7:0] burst_len;

  modport source (output valid, output action, output line_byte, output line_error,
                  output write_byte, output burst_first, output burst_len, input ready);
  modport sink   (input valid, input action, input line_byte, input line_error,
                  input write_byte, input burst_first, input burst_len, output ready);
endinterface

interface urb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       write_accepted;
  logic       overflow_seen;
  logic [7:0] rx_level;
  logic       rx_empty;
  logic [7:0] tx_level;
  logic       tx_request;

  modport source (output valid, output read_byte, output tx_valid, output tx_byte,
                  output write_accepted, output overflow_seen, output rx_level,
                  output rx_empty, output tx_level, output tx_request, input ready);
  modport sink   (input valid, input read_byte, input tx_valid, input tx_byte,
                  input write_accepted, input overflow_seen, input rx_level,
                  input rx_empty, input tx_level, input tx_request, output ready);
endinterface

// ===== rtl/uart_rx_tx_ring_buffers_core.sv =====
// Top level of the serial receive/transmit ring block.
// Each command item produces exactly one result item. The block accepts one
// item per cycle when the result side keeps up; an accepted item passes
// through the item register, loaded together with the registered read port
// of the ring memory, and then the result register, which holds it while
// the result side stalls. The receive and transmit rings are RX_DEPTH and
// TX_DEPTH bytes (128 each); they need no clearing after reset, so items are
// taken as soon as reset is released. Levels saturate at 255; a host read of
// an empty ring returns 0.
module uart_rx_tx_ring_buffers_core (
  input  logic      clk,
  input  logic      rst,
  urb_cmd_if.sink   cmd,
  urb_rsp_if.source rsp
);

  urb_pkg::cmd_t       cmd_word;
  urb_pkg::step_info_t info;
  logic [7:0]          rx_rdata;
  logic [7:0]          tx_rdata;
  logic                take;
  logic                accept;

  always_comb begin
    cmd_word.action      = cmd.action;
    cmd_word.line_byte   = cmd.line_byte;
    cmd_word.line_error  = cmd.line_error;
    cmd_word.write_byte  = cmd.write_byte;
    cmd_word.burst_first = cmd.burst_first;
    cmd_word.burst_len   = cmd.burst_len;
  end

  assign cmd.ready = take;
  assign accept    = cmd.valid && take;

  urb_ctrl ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (cmd_word),
    .info     (info),
    .rx_rdata (rx_rdata),
    .tx_rdata (tx_rdata)
  );

  urb_out res (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .info     (info),
    .rx_rdata (rx_rdata),
    .tx_rdata (tx_rdata),
    .take     (take),
    .rsp      (rsp)
  );

endmodule

// ===== rtl/urb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module urb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/urb_ctrl.sv =====
// Ring pointers, fill counts, flags and the two ring memories.
module urb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  urb_pkg::cmd_t       cmd,
  output urb_pkg::step_info_t info,
  output logic [7:0]          rx_rdata,
  output logic [7:0]          tx_rdata
);

  logic [urb_pkg::RX_AW-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [urb_pkg::RX_FW-1:0] rx_fill, rx_fill_next;
  logic [urb_pkg::TX_AW-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [urb_pkg::TX_FW-1:0] tx_fill, tx_fill_next;
  logic overflow_flag, overflow_flag_next;
  logic tx_enable, tx_enable_next;
  logic burst_ok, burst_ok_next;

  logic is_line, is_read, is_write, is_txrdy, is_clr;
  logic rx_push, rx_pop, tx_push, tx_pop, admit, push_req, wacc;
  logic [urb_pkg::ADM_W-1:0] adm_sum;

  always_comb begin
    is_line  = accept && (cmd.action == urb_pkg::ACT_LINE_BYTE);
    is_read  = accept && (cmd.action == urb_pkg::ACT_HOST_READ);
    is_write = accept && (cmd.action == urb_pkg::ACT_HOST_WRITE);
    is_txrdy = accept && (cmd.action == urb_pkg::ACT_TX_READY);
    is_clr   = accept && (cmd.action == urb_pkg::ACT_CLR_OVF);

    rx_push = is_line && !cmd.line_error && (rx_fill < urb_pkg::RX_FW'(urb_pkg::RX_DEPTH));
    rx_pop  = is_read && (rx_fill != '0);

    adm_sum  = urb_pkg::ADM_W'(cmd.burst_len) + urb_pkg::ADM_W'(tx_fill);
    admit    = adm_sum <= urb_pkg::ADM_W'(urb_pkg::TX_DEPTH);
    push_req = cmd.burst_first ? (admit && (cmd.burst_len != '0)) : burst_ok;
    tx_push  = is_write && push_req && (tx_fill < urb_pkg::TX_FW'(urb_pkg::TX_DEPTH));
    wacc     = is_write && (cmd.burst_first ? admit : burst_ok);
    tx_pop   = is_txrdy && tx_enable && (tx_fill != '0);

    rx_head_next = rx_head;
    if (rx_push) begin
      rx_head_next = (rx_head == urb_pkg::RX_AW'(urb_pkg::RX_DEPTH - 1)) ? '0 : rx_head + 1'b1;
    end
    rx_tail_next = rx_tail;
    if (rx_pop) begin
      rx_tail_next = (rx_tail == urb_pkg::RX_AW'(urb_pkg::RX_DEPTH - 1)) ? '0 : rx_tail + 1'b1;
    end
    rx_fill_next = rx_fill;
    if (rx_push) begin
      rx_fill_next = rx_fill + 1'b1;
    end else if (rx_pop) begin
      rx_fill_next = rx_fill - 1'b1;
    end

    tx_head_next = tx_head;
    if (tx_push) begin
      tx_head_next = (tx_head == urb_pkg::TX_AW'(urb_pkg::TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;
    end
    tx_tail_next = tx_tail;
    if (tx_pop) begin
      tx_tail_next = (tx_tail == urb_pkg::TX_AW'(urb_pkg::TX_DEPTH - 1)) ? '0 : tx_tail + 1'b1;
    end
    tx_fill_next = tx_fill;
    if (tx_push) begin
      tx_fill_next = tx_fill + 1'b1;
    end else if (tx_pop) begin
      tx_fill_next = tx_fill - 1'b1;
    end

    // sticky flag: set when a push lands on the last free slot
    overflow_flag_next = overflow_flag;
    if (is_clr) begin
      overflow_flag_next = 1'b0;
    end else if (rx_push && (rx_fill_next == urb_pkg::RX_FW'(urb_pkg::RX_DEPTH))) begin
      overflow_flag_next = 1'b1;
    end

    burst_ok_next = burst_ok;
    if (is_write && cmd.burst_first) begin
      burst_ok_next = admit && (cmd.burst_len != '0);
    end

    tx_enable_next = tx_enable;
    if ((is_write && cmd.burst_first && admit) || tx_push) begin
      tx_enable_next = 1'b1;
    end else if (is_txrdy && tx_enable && (tx_fill == '0)) begin
      tx_enable_next = 1'b0;
    end

    info.rx_pop         = rx_pop;
    info.tx_pop         = tx_pop;
    info.write_accepted = wacc;
    info.overflow_seen  = is_clr && overflow_flag;
    info.rx_level       = urb_pkg::sat_level(urb_pkg::SAT_W'(rx_fill_next));
    info.rx_empty       = (rx_fill_next == '0);
    info.tx_level       = urb_pkg::sat_level(urb_pkg::SAT_W'(tx_fill_next));
    info.tx_request     = tx_enable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head       <= '0;
      rx_tail       <= '0;
      rx_fill       <= '0;
      tx_head       <= '0;
      tx_tail       <= '0;
      tx_fill       <= '0;
      overflow_flag <= 1'b0;
      tx_enable     <= 1'b0;
      burst_ok      <= 1'b0;
    end else begin
      rx_head       <= rx_head_next;
      rx_tail       <= rx_tail_next;
      rx_fill       <= rx_fill_next;
      tx_head       <= tx_head_next;
      tx_tail       <= tx_tail_next;
      tx_fill       <= tx_fill_next;
      overflow_flag <= overflow_flag_next;
      tx_enable     <= tx_enable_next;
      burst_ok      <= burst_ok_next;
    end
  end

  urb_ram #(.WIDTH(8), .DEPTH(urb_pkg::RX_DEPTH)) rx_ram (
    .clk   (clk),
    .we    (rx_push),
    .waddr (rx_head),
    .wdata (cmd.line_byte),
    .re    (rx_pop),
    .raddr (rx_tail),
    .rdata (rx_rdata)
  );

  urb_ram #(.WIDTH(8), .DEPTH(urb_pkg::TX_DEPTH)) tx_ram (
    .clk   (clk),
    .we    (tx_push),
    .waddr (tx_head),
    .wdata (cmd.write_byte),
    .re    (tx_pop),
    .raddr (tx_tail),
    .rdata (tx_rdata)
  );

endmodule

// ===== rtl/urb_out.sv =====
// Read-data stage and result register with backpressure.
module urb_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  urb_pkg::step_info_t info,
  input  logic [7:0]          rx_rdata,
  input  logic [7:0]          tx_rdata,
  output logic                take,
  urb_rsp_if.source           rsp
);

  logic                s1_valid;
  urb_pkg::step_info_t s1_info;
  logic                out_valid;
  logic                s1_adv;

  always_comb begin
    s1_adv = s1_valid && (!out_valid || rsp.ready);
    take   = !s1_valid || s1_adv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info;
    end
    // RAM read data is valid while the item sits in s1; fold it in on advance
    if (s1_adv) begin
      rsp.read_byte      <= s1_info.rx_pop ? rx_rdata : 8'd0;
      rsp.tx_valid       <= s1_info.tx_pop;
      rsp.tx_byte        <= s1_info.tx_pop ? tx_rdata : 8'd0;
      rsp.write_accepted <= s1_info.write_accepted;
      rsp.overflow_seen  <= s1_info.overflow_seen;
      rsp.rx_level       <= s1_info.rx_level;
      rsp.rx_empty       <= s1_info.rx_empty;
      rsp.tx_level       <= s1_info.tx_level;
      rsp.tx_request     <= s1_info.tx_request;
    end
  end

  assign rsp.valid = out_valid;

endmodule

// ===== rtl/urb_check.sv =====
// Port-level checks for the ring block, bound to the top level.
module urb_check (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] read_byte,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic [7:0] rx_level,
  input logic       rx_empty,
  input logic       tx_request
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_byte) && $stable(tx_byte))
    else $error("result changed while stalled");

  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rx_empty == (rx_level == 8'd0)))
    else $error("rx_empty disagrees with rx_level");

  a_tx_byte_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !tx_valid |-> tx_byte == 8'd0)
    else $error("tx_byte set without tx_valid");

  a_pop_keeps_req: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && tx_valid |-> tx_request)
    else $error("transmit pop reported with request off");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind uart_rx_tx_ring_buffers_core urb_check chk (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .read_byte  (rsp.read_byte),
  .tx_valid   (rsp.tx_valid),
  .tx_byte    (rsp.tx_byte),
  .rx_level   (rsp.rx_level),
  .rx_empty   (rsp.rx_empty),
  .tx_request (rsp.tx_request)
);

// ===== test/tb_uart_rx_tx_ring_buffers_core.sv =====
// Self-checking testbench for the serial receive/transmit ring block.
module tb_uart_rx_tx_ring_buffers_core;
  import urb_pkg::*;

  localparam int         RANDOM_ITEMS     = 1500;
  localparam int         LONG_HOLD_CYCLES = 300;
  localparam int         TIMEOUT_CYCLES   = 200000;
  localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       write_accepted;
    logic       overflow_seen;
    logic [7:0] rx_level;
    logic       rx_empty;
    logic [7:0] tx_level;
    logic       tx_request;
  } ring_result_t;

  typedef enum {STALL_NONE, STALL_HALF, STALL_SPARSE, STALL_LIGHT} stall_mode_e;

  class ring_scoreboard;
    logic [7:0]   rx_mem [RX_DEPTH];
    logic [7:0]   tx_mem [TX_DEPTH];
    int           rx_wr, rx_rd, rx_count;
    int           tx_wr, tx_rd, tx_count;
    bit           overflow, tx_enabled, burst_open;
    ring_result_t pending [$];
    int           errors;

    function new();
      rx_wr = 0; rx_rd = 0; rx_count = 0;
      tx_wr = 0; tx_rd = 0; tx_count = 0;
      overflow = 0; tx_enabled = 0; burst_open = 0;
      errors = 0;
    endfunction

    function void tx_store(logic [7:0] b);
      if (tx_count < TX_DEPTH) begin
        tx_mem[tx_wr] = b;
        tx_wr = (tx_wr + 1) % TX_DEPTH;
        tx_count++;
        tx_enabled = 1;
      end
    endfunction

    // Advance the ring state for one accepted item and queue its result
    function void note_cmd(cmd_t c);
      ring_result_t e;
      e = '0;
      case (c.action)
        ACT_LINE_BYTE: begin
          if (!c.line_error && rx_count < RX_DEPTH) begin
            rx_mem[rx_wr] = c.line_byte;
            rx_wr = (rx_wr + 1) % RX_DEPTH;
            rx_count++;
            if (rx_count == RX_DEPTH) overflow = 1;
          end
        end
        ACT_HOST_READ: begin
          if (rx_count > 0) begin
            e.read_byte = rx_mem[rx_rd];
            rx_rd = (rx_rd + 1) % RX_DEPTH;
            rx_count--;
          end
        end
        ACT_HOST_WRITE: begin
          if (c.burst_first) begin
            if (int'(c.burst_len) + tx_count <= TX_DEPTH) begin
              e.write_accepted = 1;
              tx_enabled = 1;
              burst_open = (c.burst_len != 0);
              if (burst_open) tx_store(c.write_byte);
            end else begin
              burst_open = 0;
            end
          end else if (burst_open) begin
            e.write_accepted = 1;
            tx_store(c.write_byte);
          end
        end
        ACT_TX_READY: begin
          if (tx_enabled) begin
            if (tx_count > 0) begin
              e.tx_valid = 1;
              e.tx_byte = tx_mem[tx_rd];
              tx_rd = (tx_rd + 1) % TX_DEPTH;
              tx_count--;
            end else begin
              tx_enabled = 0;
            end
          end
        end
        ACT_CLR_OVF: begin
          e.overflow_seen = overflow;
          overflow = 0;
        end
        default: ;
      endcase
      e.rx_level   = (rx_count > 255) ? 8'hFF : 8'(rx_count);
      e.rx_empty   = (rx_count == 0);
      e.tx_level   = (tx_count > 255) ? 8'hFF : 8'(tx_count);
      e.tx_request = tx_enabled;
      pending.push_back(e);
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_rsp(ring_result_t got);
      ring_result_t want;
      if (pending.size() == 0) begin
        $error("result item arrived with nothing outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      compare("read_byte", want.read_byte, got.read_byte);
      compare("tx_valid", want.tx_valid, got.tx_valid);
      compare("tx_byte", want.tx_byte, got.tx_byte);
      compare("write_accepted", want.write_accepted, got.write_accepted);
      compare("overflow_seen", want.overflow_seen, got.overflow_seen);
      compare("rx_level", want.rx_level, got.rx_level);
      compare("rx_empty", want.rx_empty, got.rx_empty);
      compare("tx_level", want.tx_level, got.tx_level);
      compare("tx_request", want.tx_request, got.tx_request);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  urb_cmd_if cmd ();
  urb_rsp_if rsp ();

  uart_rx_tx_ring_buffers_core uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  ring_scoreboard sb = new();

  int live_items = 0;
  int burst_left = 0;
  bit sender_steady = 1'b1;
  bit hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("[uart_rx_tx_ring_buffers_core] ERROR");
    $finish;
  end

  function automatic cmd_t mk(logic [2:0] act, logic [7:0] lbyte, logic lerr,
                              logic [7:0] wbyte, logic first, logic [7:0] len);
    cmd_t c;
    c.action      = act;
    c.line_byte   = lbyte;
    c.line_error  = lerr;
    c.write_byte  = wbyte;
    c.burst_first = first;
    c.burst_len   = len;
    return c;
  endfunction

  function automatic cmd_t rand_cmd(logic [2:0] act);
    return mk(act, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
              8'($urandom));
  endfunction

  // Offer one item in sender bursts; hold it until the block takes it
  task automatic send_cmd(input cmd_t c);
    int gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        cmd.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    cmd.valid       <= 1'b1;
    cmd.action      <= c.action;
    cmd.line_byte   <= c.line_byte;
    cmd.line_error  <= c.line_error;
    cmd.write_byte  <= c.write_byte;
    cmd.burst_first <= c.burst_first;
    cmd.burst_len   <= c.burst_len;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    sb.note_cmd(c);
    if (c.action <= ACT_CLR_OVF) live_items++;
  endtask

  task automatic wait_results_drained();
    cmd.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // Weighted mix of single-item actions; the remainder is any action code
  task automatic mix_phase(input int n, input int w_line, input int w_read,
                           input int w_ready, input int w_clr);
    cmd_t c;
    int   r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < w_line) begin
        c = rand_cmd(ACT_LINE_BYTE);
        c.line_error = ($urandom_range(0, 9) == 0);
      end else if (r < w_line + w_read) begin
        c = rand_cmd(ACT_HOST_READ);
      end else if (r < w_line + w_read + w_ready) begin
        c = rand_cmd(ACT_TX_READY);
      end else if (r < w_line + w_read + w_ready + w_clr) begin
        c = rand_cmd(ACT_CLR_OVF);
      end else begin
        c = rand_cmd(3'($urandom_range(0, 7)));
      end
      send_cmd(c);
    end
  endtask

  task automatic burst_phase(input int bursts);
    cmd_t c;
    int   len, room, tail_bytes, r;
    repeat (bursts) begin
      r = $urandom_range(0, 99);
      room = TX_DEPTH - sb.tx_count;
      if (r < 10) begin
        len = 0;
      end else if (r < 30) begin
        len = $urandom_range(1, 8);
      end else if (r < 55) begin
        // aim at the admission boundary
        len = room + $urandom_range(0, 4) - 2;
        if (len < 0) len = 0;
        if (len > 255) len = 255;
      end else if (r < 70) begin
        len = $urandom_range(0, 255);
      end else begin
        len = $urandom_range(1, 40);
      end
      if ($urandom_range(0, 9) == 0) begin
        c = rand_cmd(ACT_HOST_WRITE);
        c.burst_first = 1'b0;
        send_cmd(c);
      end
      c = rand_cmd(ACT_HOST_WRITE);
      c.burst_first = 1'b1;
      c.burst_len   = 8'(len);
      send_cmd(c);
      tail_bytes = (len > 0) ? len - 1 : $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < 15) tail_bytes += $urandom_range(1, 3);
      else if (r < 25) tail_bytes = $urandom_range(0, tail_bytes);
      repeat (tail_bytes) begin
        if ($urandom_range(0, 9) == 0) send_cmd(rand_cmd(ACT_TX_READY));
        c = rand_cmd(ACT_HOST_WRITE);
        c.burst_first = 1'b0;
        send_cmd(c);
      end
    end
  endtask

  // Result side: check every accepted item, stall on a changing pattern
  initial begin
    stall_mode_e mode;
    int          mode_left;
    int          hold_left;
    mode = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        sb.check_rsp('{read_byte: rsp.read_byte, tx_valid: rsp.tx_valid,
                       tx_byte: rsp.tx_byte, write_accepted: rsp.write_accepted,
                       overflow_seen: rsp.overflow_seen, rx_level: rsp.rx_level,
                       rx_empty: rsp.rx_empty, tx_level: rsp.tx_level,
                       tx_request: rsp.tx_request});
      end
      if (hold_req) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        case (mode)
          STALL_NONE:   rsp.ready <= 1'b1;
          STALL_HALF:   rsp.ready <= ($urandom_range(0, 1) == 1);
          STALL_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
          default:      rsp.ready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  initial begin
    int start_items;
    int r;
    rst             <= 1'b1;
    cmd.valid       <= 1'b0;
    cmd.action      <= ACT_LINE_BYTE;
    cmd.line_byte   <= 8'h00;
    cmd.line_error  <= 1'b0;
    cmd.write_byte  <= 8'h00;
    cmd.burst_first <= 1'b0;
    cmd.burst_len   <= 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty read, ready tick while disabled, clear with flag low
    send_cmd(mk(ACT_HOST_READ, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    send_cmd(mk(ACT_TX_READY, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    send_cmd(mk(ACT_CLR_OVF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    // errored byte is dropped; extremes of the line byte are stored
    send_cmd(mk(ACT_LINE_BYTE, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00));
    send_cmd(mk(ACT_LINE_BYTE, 8'h00, 1'b0, 8'hFF, 1'b1, 8'hFF));
    send_cmd(mk(ACT_LINE_BYTE, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00));
    send_cmd(mk(ACT_HOST_READ, 8'hFF, 1'b1, 8'hFF, 1'b1, 8'hFF));
    send_cmd(mk(ACT_HOST_READ, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    // zero-length burst, then a rejected one, each with a trailing byte
    send_cmd(mk(ACT_HOST_WRITE, 8'h00, 1'b0, 8'hAA, 1'b1, 8'h00));
    send_cmd(mk(ACT_HOST_WRITE, 8'h00, 1'b0, 8'h55, 1'b0, 8'h00));
    send_cmd(mk(ACT_HOST_WRITE, 8'h00, 1'b0, 8'hFF, 1'b1, 8'hFF));
    send_cmd(mk(ACT_HOST_WRITE, 8'h00, 1'b0, 8'h00, 1'b0, 8'hFF));
    // admitted burst of three plus one extra byte
    send_cmd(mk(ACT_HOST_WRITE, 8'h00, 1'b0, 8'hFF, 1'b1, 8'h03));
    send_cmd(mk(ACT_HOST_WRITE, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    send_cmd(mk(ACT_HOST_WRITE, 8'h00, 1'b0, 8'h5A, 1'b0, 8'h00));
    send_cmd(mk(ACT_HOST_WRITE, 8'h00, 1'b0, 8'hC3, 1'b0, 8'h00));
    // drain four, find the ring empty, then tick while disabled
    repeat (6) send_cmd(mk(ACT_TX_READY, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    send_cmd(mk(ACT_FIRST_UNUSED, 8'hFF, 1'b0, 8'hFF, 1'b1, 8'hFF));
    send_cmd(mk(ACT_FIRST_UNUSED + 3'd1, 8'h00, 1'b1, 8'h00, 1'b0, 8'h01));
    send_cmd(mk(ACT_FIRST_UNUSED + 3'd2, 8'h5A, 1'b0, 8'hA5, 1'b1, 8'h80));
    wait_results_drained();

    // fill the receive ring against a long result stall
    start_items = live_items;
    hold_req = 1'b1;
    mix_phase(200, 90, 5, 0, 5);
    wait_results_drained();

    while (live_items - start_items < RANDOM_ITEMS) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      case (r)
        0, 1:    mix_phase($urandom_range(60, 200), 85, 8, 2, 3);
        2, 3:    mix_phase($urandom_range(40, 160), 15, 75, 5, 3);
        4, 5, 6: burst_phase($urandom_range(1, 6));
        7, 8:    mix_phase($urandom_range(40, 160), 5, 5, 80, 2);
        default: mix_phase($urandom_range(20, 60), 0, 0, 0, 0);
      endcase
      if ($urandom_range(0, 3) == 0) wait_results_drained();
    end

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[uart_rx_tx_ring_buffers_core] OK");
    end else begin
      $display("[uart_rx_tx_ring_buffers_core] ERROR");
    end
    $finish;
  end

endmodule
